/* rtl/rational_fraction_alu_assert.svh */
// assertion macros for the fraction alu checker
// needs nothing else; included by the checker file only
`ifndef RATIONAL_FRACTION_ALU_ASSERT_SVH
`define RATIONAL_FRACTION_ALU_ASSERT_SVH

// same-cycle implication under the active-low reset
`define RFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the active-low reset
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rfa_pkg.sv */
// shared types and constants of the fraction alu
// no dependencies; used by the interfaces, the divider and the top level
package rfa_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_TEST,
    ST_GCD_WAIT,
    ST_LQ_WAIT,
    ST_RQ_WAIT,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_FINISH
  } state_e;

endpackage

/* rtl/rfa_if.sv */
// valid/ready channel interfaces for operand and result items
// depends on rfa_pkg for the default operand width
interface rfa_in_if #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic signed [OPERAND_WIDTH-1:0] left_num;
  logic signed [OPERAND_WIDTH-1:0] left_den;
  logic signed [OPERAND_WIDTH-1:0] right_num;
  logic signed [OPERAND_WIDTH-1:0] right_den;

  modport source (
    output valid, opcode, left_num, left_den, right_num, right_den,
    input  ready
  );
  modport sink (
    input  valid, opcode, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

interface rfa_out_if #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [2*OPERAND_WIDTH-1:0] result_num;
  logic signed [2*OPERAND_WIDTH-1:0] result_den;
  logic                              div_zero_error;

  modport source (
    output valid, result_num, result_den, div_zero_error,
    input  ready
  );
  modport sink (
    input  valid, result_num, result_den, div_zero_error,
    output ready
  );
endinterface

/* rtl/rfa_div.sv */
// restoring unsigned divider, one quotient bit per cycle
// depends on rfa_pkg for the default width; shared by gcd steps and the two lcm quotients
module rfa_div #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [OPERAND_WIDTH-1:0] dividend_i,
  input  logic [OPERAND_WIDTH-1:0] divisor_i,
  output logic                     done_o,
  output logic [OPERAND_WIDTH-1:0] quotient_o,
  output logic [OPERAND_WIDTH-1:0] remainder_o
);
  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  dvs_q;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // one restoring step
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  // control: step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // data: partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], fits};
      rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/rational_fraction_alu.sv */
// channel    dir  handshake    payload
// in_i       in   valid/ready  opcode, left_num, left_den, right_num, right_den
// out_o      out  valid/ready  result_num, result_den, div_zero_error
//
// mul/div run mul_a and mul_c, then the result register loads in finish;
// add/sub with a zero denominator go straight to finish; other add/sub run
// euclid steps on the shared divider, two lcm quotient divisions and three
// multiplies; in_i is ready only in idle
// the result register holds until taken, the next item may enter meanwhile
// reset is asynchronous active low and clears sequencer and output valid
module rational_fraction_alu #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfa_in_if.sink    in_i,
  rfa_out_if.source out_o
);
  import rfa_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned RW = 2 * W;
  localparam int unsigned QW = W + 1;
  localparam int unsigned PW = 2 * QW;

  state_e state_q, state_d;

  // captured operands
  opcode_e             op_q;
  logic signed [W-1:0] ln_q, ld_q, rn_q, rd_q;
  logic                err_q;
  logic                addsub;

  // euclid and quotient registers
  logic [W-1:0]         a_q, b_q;
  logic signed [QW-1:0] lq_q, rq_q;
  logic [W-1:0]         mag_ld, mag_rd, in_mag_ld, in_mag_rd;

  // products
  logic [RW-1:0]        num_q, den_q, prod_q;
  logic signed [QW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] product;
  logic [RW-1:0]        prod_trunc;

  // divider hookup
  logic         div_start;
  logic [W-1:0] div_dividend, div_divisor;
  logic         div_done;
  logic [W-1:0] div_quo, div_rem;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 load_out;
  logic [RW-1:0]        res_num_q, res_den_q;
  logic                 res_err_q;

  logic                 in_ready;
  logic                 accept;
  logic                 in_addsub;
  logic                 in_err;

  assign in_ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_ready;
  assign addsub   = (op_q == OP_ADD) || (op_q == OP_SUB);

  // magnitudes of denominators
  assign in_mag_ld = in_i.left_den[W-1]  ? W'(0) - $unsigned(in_i.left_den)
                                         : $unsigned(in_i.left_den);
  assign in_mag_rd = in_i.right_den[W-1] ? W'(0) - $unsigned(in_i.right_den)
                                         : $unsigned(in_i.right_den);
  assign mag_ld    = ld_q[W-1] ? W'(0) - $unsigned(ld_q) : $unsigned(ld_q);
  assign mag_rd    = rd_q[W-1] ? W'(0) - $unsigned(rd_q) : $unsigned(rd_q);

  // zero denominator check on the incoming item
  always_comb begin
    in_addsub = (opcode_e'(in_i.opcode) == OP_ADD) || (opcode_e'(in_i.opcode) == OP_SUB);
    if (opcode_e'(in_i.opcode) == OP_DIV) begin
      in_err = (in_i.left_den == '0) || (in_i.right_num == '0);
    end else begin
      in_err = (in_i.left_den == '0) || (in_i.right_den == '0);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_addsub) begin
            state_d = in_err ? ST_FINISH : ST_GCD_TEST;
          end else begin
            state_d = ST_MUL_A;
          end
        end
      end
      ST_GCD_TEST: state_d = (b_q == '0) ? ST_LQ_WAIT : ST_GCD_WAIT;
      ST_GCD_WAIT: if (div_done) state_d = ST_GCD_TEST;
      ST_LQ_WAIT:  if (div_done) state_d = ST_RQ_WAIT;
      ST_RQ_WAIT:  if (div_done) state_d = ST_MUL_A;
      ST_MUL_A:    state_d = addsub ? ST_MUL_B : ST_MUL_C;
      ST_MUL_B:    state_d = ST_MUL_C;
      ST_MUL_C:    state_d = ST_FINISH;
      ST_FINISH:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: divider start, multiplier operands and result load
  always_comb begin
    div_start    = 1'b0;
    div_dividend = a_q;
    div_divisor  = b_q;
    mul_a        = QW'(ln_q);
    mul_b        = QW'(rd_q);
    load_out     = 1'b0;
    unique case (state_q)
      ST_GCD_TEST: begin
        div_start = 1'b1;
        if (b_q == '0) begin
          div_dividend = mag_ld;
          div_divisor  = a_q;
        end
      end
      ST_LQ_WAIT: begin
        div_start    = div_done;
        div_dividend = mag_rd;
        div_divisor  = a_q;
      end
      ST_MUL_A: begin
        mul_a = QW'(ln_q);
        if (addsub) begin
          mul_b = rq_q;
        end else if (op_q == OP_MUL) begin
          mul_b = QW'(rn_q);
        end else begin
          mul_b = QW'(rd_q);
        end
      end
      ST_MUL_B: begin
        mul_a = QW'(rn_q);
        mul_b = lq_q;
      end
      ST_MUL_C: begin
        mul_a = addsub ? lq_q : QW'(ld_q);
        mul_b = (op_q == OP_DIV) ? QW'(rn_q) : QW'(rd_q);
      end
      ST_FINISH: load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // shared multiplier, result always lands in a register
  assign product    = mul_a * mul_b;
  assign prod_trunc = product[RW-1:0];

  // operand, euclid, quotient and product registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_e'(in_i.opcode);
      ln_q  <= in_i.left_num;
      ld_q  <= in_i.left_den;
      rn_q  <= in_i.right_num;
      rd_q  <= in_i.right_den;
      err_q <= in_err;
      a_q   <= in_mag_ld;
      b_q   <= in_mag_rd;
    end
    if (state_q == ST_GCD_WAIT && div_done) begin
      a_q <= b_q;
      b_q <= div_rem;
    end
    if (state_q == ST_LQ_WAIT && div_done) begin
      lq_q <= ld_q[W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
    if (state_q == ST_RQ_WAIT && div_done) begin
      rq_q <= rd_q[W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
    if (state_q == ST_MUL_A) begin
      num_q <= prod_trunc;
    end
    if (state_q == ST_MUL_B) begin
      prod_q <= prod_trunc;
    end
    if (state_q == ST_MUL_C) begin
      den_q <= prod_trunc;
      if (addsub) begin
        num_q <= (op_q == OP_ADD) ? num_q + prod_q : num_q - prod_q;
      end
    end
  end

  // result register, zeroed on error
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_num_q <= err_q ? '0 : num_q;
      res_den_q <= err_q ? '0 : den_q;
      res_err_q <= err_q;
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  rfa_div #(
    .OPERAND_WIDTH(W)
  ) u_rfa_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.result_num     = $signed(res_num_q);
  assign out_o.result_den     = $signed(res_den_q);
  assign out_o.div_zero_error = res_err_q;

endmodule

/* rtl/rfa_checker.sv */
// port-level checks of the fraction alu, bound to the top level
// depends on rational_fraction_alu_assert.svh and rfa_pkg
`include "rational_fraction_alu_assert.svh"

module rfa_checker #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [2*OPERAND_WIDTH-1:0]   out_num_i,
  input logic [2*OPERAND_WIDTH-1:0]   out_den_i,
  input logic                         out_err_i
);
  import rfa_pkg::*;

  // a stalled result item holds
  `RFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_num_i) && $stable(out_den_i) && $stable(out_err_i), "result item changed while stalled")

  // one item at a time: ready drops after an accept
  `RFA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after accept")

  // error results are all zero
  `RFA_ASSERT_SAME(a_err_zero, clk_i, rst_ni, out_valid_i && out_err_i, (out_num_i == '0) && (out_den_i == '0), "error result not zeroed")

  // a good result never has a zero denominator
  `RFA_ASSERT_SAME(a_den_nonzero, clk_i, rst_ni, out_valid_i && !out_err_i, out_den_i != '0, "zero denominator without error")

endmodule

bind rational_fraction_alu rfa_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_rfa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_num_i  (out_o.result_num),
  .out_den_i  (out_o.result_den),
  .out_err_i  (out_o.div_zero_error)
);
